// ===== src/trmbb_pkg.sv =====
`default_nettype none
package trmbb_pkg;

  // Default store sizes
  localparam int GLYPH_COUNT_DEF = 256;
  localparam int CELL_COUNT_DEF  = 768;

  // Tile geometry: 8 rows of 8 pixels, row r in bits 8r+7..8r
  localparam int TILE_W = 64;

  // Item fields
  localparam int GIDX_W = 8;
  localparam int MODE_W = 7;
  localparam int CIDX_W = 10;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // Draw mode bit positions
  localparam int MODE_MERGE_LO = 2;
  localparam int MODE_ROT_LO   = 4;
  localparam int MODE_MIRROR   = 6;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic [1:0] {
    MERGE_REPLACE = 2'd0,
    MERGE_OR      = 2'd1,
    MERGE_AND     = 2'd2,
    MERGE_XOR     = 2'd3
  } merge_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_wr;  // write zero at the clear pointer
    logic accept;    // input transfer this cycle
    logic commit;    // write back the merged cell and load the result
  } trmbb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // clear pointer at the last cell
    logic out_free;    // result register can take a new result
  } trmbb_status_t;

  // Rotate a tile; pure wiring
  function automatic logic [TILE_W-1:0] rotate_tile(logic [TILE_W-1:0] g, rot_t rot);
    logic [TILE_W-1:0] t;
    t = '0;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        unique case (rot)
          ROT_0:   t[i*8 + j]             = g[i*8 + j];
          ROT_90:  t[(7-i)*8 + j]         = g[j*8 + i];
          ROT_180: t[(7-i)*8 + (7-j)]     = g[i*8 + j];
          ROT_270: t[i*8 + (7-j)]         = g[j*8 + i];
          default: t[i*8 + j]             = g[i*8 + j];
        endcase
      end
    end
    return t;
  endfunction

  // Bit-reverse every row
  function automatic logic [TILE_W-1:0] mirror_rows(logic [TILE_W-1:0] g);
    logic [TILE_W-1:0] t;
    t = '0;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        t[i*8 + (7-j)] = g[i*8 + j];
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== src/trmbb_in_if.sv =====
`default_nettype none
interface trmbb_in_if
  import trmbb_pkg::*;
;
  logic                valid;
  logic                ready;
  logic                op;
  logic [GIDX_W-1:0]   glyph_index;
  logic [TILE_W-1:0]   glyph_pattern;
  logic [MODE_W-1:0]   draw_mode;
  logic [CIDX_W-1:0]   cell_index;

  modport source (
    output valid, op, glyph_index, glyph_pattern, draw_mode, cell_index,
    input  ready
  );

  modport sink (
    input  valid, op, glyph_index, glyph_pattern, draw_mode, cell_index,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/trmbb_out_if.sv =====
`default_nettype none
interface trmbb_out_if
  import trmbb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [TILE_W-1:0] cell_pattern;
  logic              cell_out_of_range;

  modport source (
    output valid, cell_pattern, cell_out_of_range,
    input  ready
  );

  modport sink (
    input  valid, cell_pattern, cell_out_of_range,
    output ready
  );
endinterface
`default_nettype wire

// ===== src/tile_rotate_mirror_blend_blit_unit.sv =====
// Channel  Role    Transfer moves
// -------  ------  ---------------------------------------------------------
// item     sink    op, glyph_index, glyph_pattern, draw_mode, cell_index
// result   source  cell_pattern, cell_out_of_range (one per draw, none per load)
//
// A load writes an in-range glyph into the glyph store as it is taken. A draw
// reads the glyph and cell stores (registered single read port each), then
// rotates, merges and writes the cell back through the cell store's single write port.
// After reset the cell store is cleared one cell per cycle, with item ready
// low. A draw holds in its merge cycle while the result register is full
// and not taken; a new item is taken while a result waits.
`default_nettype none
module tile_rotate_mirror_blend_blit_unit
  import trmbb_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
  parameter int CELL_COUNT  = CELL_COUNT_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  trmbb_in_if.sink    item,
  trmbb_out_if.source result
);

  trmbb_cmd_t    cmd;
  trmbb_status_t status;

  trmbb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_op    (item.op),
    .item_ready (item.ready),
    .status     (status),
    .cmd        (cmd)
  );

  trmbb_datapath #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .CELL_COUNT  (CELL_COUNT)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .op                (item.op),
    .glyph_index       (item.glyph_index),
    .glyph_pattern     (item.glyph_pattern),
    .draw_mode         (item.draw_mode),
    .cell_index        (item.cell_index),
    .res_valid         (result.valid),
    .res_ready         (result.ready),
    .cell_pattern      (result.cell_pattern),
    .cell_out_of_range (result.cell_out_of_range)
  );

endmodule
`default_nettype wire

// ===== src/trmbb_ctrl.sv =====
`default_nettype none
module trmbb_ctrl
  import trmbb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire logic          item_op,
  output logic               item_ready,
  input  wire trmbb_status_t status,
  output trmbb_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_MERGE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Take items only between draws
  assign item_ready   = (state == ST_IDLE);
  assign cmd.accept   = item_ready && item_valid;
  assign cmd.clear_wr = (state == ST_CLEAR);
  assign cmd.commit   = (state == ST_MERGE) && status.out_free;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.accept && item_op == OP_DRAW) state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/trmbb_datapath.sv =====
`default_nettype none
module trmbb_datapath
  import trmbb_pkg::*;
#(
  parameter int GLYPH_COUNT = GLYPH_COUNT_DEF,
  parameter int CELL_COUNT  = CELL_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire trmbb_cmd_t        cmd,
  output trmbb_status_t          status,
  input  wire logic              op,
  input  wire logic [GIDX_W-1:0] glyph_index,
  input  wire logic [TILE_W-1:0] glyph_pattern,
  input  wire logic [MODE_W-1:0] draw_mode,
  input  wire logic [CIDX_W-1:0] cell_index,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic [TILE_W-1:0]      cell_pattern,
  output logic                   cell_out_of_range
);

  localparam int GA_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int CA_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  logic [TILE_W-1:0] glyph_mem [GLYPH_COUNT];
  logic [TILE_W-1:0] cell_mem  [CELL_COUNT];

  logic [TILE_W-1:0] glyph_rd;
  logic [TILE_W-1:0] cell_rd;
  logic              glyph_ok;
  logic              cell_ok;
  logic [CA_W-1:0]   cell_addr;
  rot_t              rot;
  merge_t            merge;
  logic              mirror_off;
  logic [CA_W-1:0]   clear_ptr;

  logic              glyph_in_range;
  logic              cell_in_range;
  logic              glyph_wr;
  logic              cell_wr;
  logic [CA_W-1:0]   cell_wr_addr;
  logic [TILE_W-1:0] cell_wr_data;
  logic [TILE_W-1:0] glyph_src;
  logic [TILE_W-1:0] rotated;
  logic [TILE_W-1:0] shaped;
  logic [TILE_W-1:0] merged;

  assign glyph_in_range = ({24'b0, glyph_index} < 32'(GLYPH_COUNT));
  assign cell_in_range  = ({22'b0, cell_index} < 32'(CELL_COUNT));
  assign glyph_wr       = cmd.accept && (op == OP_LOAD) && glyph_in_range;

  // Glyph store: write on in-range load, read on every transfer
  always_ff @(posedge clk) begin
    if (glyph_wr) begin
      glyph_mem[glyph_index[GA_W-1:0]] <= glyph_pattern;
    end
    if (cmd.accept) begin
      glyph_rd <= glyph_mem[glyph_index[GA_W-1:0]];
    end
  end

  // Cell store write port: clearing pass or draw write-back
  assign cell_wr      = cmd.clear_wr || (cmd.commit && cell_ok);
  assign cell_wr_addr = cmd.clear_wr ? clear_ptr : cell_addr;
  assign cell_wr_data = cmd.clear_wr ? '0 : merged;

  always_ff @(posedge clk) begin
    if (cell_wr) begin
      cell_mem[cell_wr_addr] <= cell_wr_data;
    end
    if (cmd.accept) begin
      cell_rd <= cell_mem[cell_index[CA_W-1:0]];
    end
  end

  // Hold the draw controls for the merge cycle
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      glyph_ok   <= glyph_in_range;
      cell_ok    <= cell_in_range;
      cell_addr  <= cell_index[CA_W-1:0];
      rot        <= rot_t'(draw_mode[MODE_ROT_LO +: 2]);
      merge      <= merge_t'(draw_mode[MODE_MERGE_LO +: 2]);
      mirror_off <= draw_mode[MODE_MIRROR];
    end
  end

  // Advance the clear pointer during the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_ptr <= '0;
    end else if (cmd.clear_wr && !status.clear_last) begin
      clear_ptr <= clear_ptr + CA_W'(1);
    end
  end

  assign status.clear_last = (clear_ptr == CA_W'(CELL_COUNT - 1));
  assign status.out_free   = !res_valid || res_ready;

  // Rotate, mirror and merge
  assign glyph_src = glyph_ok ? glyph_rd : '0;
  assign rotated   = rotate_tile(glyph_src, rot);
  assign shaped    = mirror_off ? rotated : mirror_rows(rotated);

  always_comb begin
    unique case (merge)
      MERGE_XOR:     merged = cell_rd ^ shaped;
      MERGE_AND:     merged = cell_rd & shaped;
      MERGE_OR:      merged = cell_rd | shaped;
      MERGE_REPLACE: merged = shaped;
      default:       merged = shaped;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      cell_pattern      <= cell_ok ? merged : '0;
      cell_out_of_range <= !cell_ok;
    end
  end

endmodule
`default_nettype wire
